[rtl/core/mtwr_pkg.sv]
// Shared constants, the closed-window record type and a helper function for the reorder unit.
package mtwr_pkg;

    localparam int WINDOW_MAX  = 8;
    localparam int DATA_WIDTH  = 32;
    localparam int CFG_W       = 4;
    localparam int POS_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int DIST_W      = $clog2(DATA_WIDTH + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = CFG_W'(4);

    // One closed window as handed from the front to the back.
    typedef struct packed {
        logic [WINDOW_MAX-1:0][DATA_WIDTH-1:0] words;
        logic [WINDOW_MAX-1:0][POS_W-1:0]      pos;
        logic [CNT_W-1:0]                      count;
    } win_rec_t;

    function automatic logic [DIST_W-1:0] bit_count(input logic [DATA_WIDTH-1:0] v);
        logic [DIST_W-1:0] n;
        n = '0;
        for (int i = 0; i < DATA_WIDTH; i++)
        begin
            n = n + DIST_W'(v[i]);
        end
        return n;
    endfunction

endpackage

[rtl/core/mtwr_if.sv]
// Handshake interfaces for the word, result and configuration channels.
interface mtwr_in_if;
    logic                             valid;
    logic                             ready;
    logic [mtwr_pkg::DATA_WIDTH-1:0]  data_word;
    logic                             end_of_stream;

    modport source (output valid, output data_word, output end_of_stream, input ready);
    modport sink   (input valid, input data_word, input end_of_stream, output ready);
endinterface

interface mtwr_out_if;
    logic                             valid;
    logic                             ready;
    logic [mtwr_pkg::DATA_WIDTH-1:0]  out_word;
    logic [mtwr_pkg::POS_W-1:0]       orig_position;
    logic                             window_last;

    modport source (output valid, output out_word, output orig_position,
                    output window_last, input ready);
    modport sink   (input valid, input out_word, input orig_position,
                    input window_last, output ready);
endinterface

interface mtwr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mtwr_pkg::CFG_W-1:0]   window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

[rtl/core/mtwr_front.sv]
// Front part: holds the window size, gathers words into the open window and closes it.
module mtwr_front (
    input  logic               clk,
    input  logic               rst_n,
    mtwr_in_if.sink            words,
    mtwr_cfg_if.sink           cfg,
    input  logic               queue_full,
    output logic               queue_push,
    output mtwr_pkg::win_rec_t queue_rec
);
    import mtwr_pkg::*;

    logic [CFG_W-1:0]                      window_size_reg;
    logic [CNT_W-1:0]                      fill_reg;
    logic [CNT_W-1:0]                      fill_next;
    logic [WINDOW_MAX-1:0][DATA_WIDTH-1:0] word_reg;
    logic [WINDOW_MAX-1:0][DATA_WIDTH-1:0] word_next;
    logic [WINDOW_MAX-1:0][POS_W-1:0]      pos_reg;
    logic [WINDOW_MAX-1:0][POS_W-1:0]      pos_next;
    logic [CNT_W-1:0]                      eff_size;
    logic [CNT_W-1:0]                      fill_inc;
    logic [POS_W-1:0]                      slot;
    logic                                  accept;
    logic                                  close;

    assign cfg.ready   = 1'b1;
    assign words.ready = !queue_full;
    assign accept      = words.valid && words.ready;

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            eff_size = CNT_W'(1);
        end
        else if (int'(window_size_reg) > WINDOW_MAX)
        begin
            eff_size = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            eff_size = CNT_W'(window_size_reg);
        end
    end

    // A full window always closes, so the fill count is below the depth on every accept.
    assign slot     = fill_reg[POS_W-1:0];
    assign fill_inc = fill_reg + 1'b1;
    assign close    = words.end_of_stream || (fill_inc >= eff_size);
    assign fill_next = close ? '0 : fill_inc;

    // Each slot keeps the highest position holding an equal word, so earlier
    // duplicates are pointed at the new slot as it is written.
    always_comb
    begin
        word_next = word_reg;
        pos_next  = pos_reg;
        for (int j = 0; j < WINDOW_MAX; j++)
        begin
            if ((j < int'(fill_reg)) && (word_reg[j] == words.data_word))
            begin
                pos_next[j] = slot;
            end
        end
        word_next[slot] = words.data_word;
        pos_next[slot]  = slot;
    end

    assign queue_push      = accept && close;
    assign queue_rec.words = word_next;
    assign queue_rec.pos   = pos_next;
    assign queue_rec.count = fill_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
            fill_reg        <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                window_size_reg <= cfg.window_size;
            end
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

[rtl/core/mtwr_queue.sv]
// Short queue of closed windows between the front and the back.
module mtwr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mtwr_pkg::win_rec_t push_rec,
    output logic               full,
    input  logic               pop,
    output mtwr_pkg::win_rec_t pop_rec,
    output logic               empty
);
    import mtwr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    win_rec_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (level_reg == LVL_W'(QUEUE_DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (int'(p) == QUEUE_DEPTH - 1)
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

[rtl/core/mtwr_back.sv]
// Back part: drains one closed window in greedy minimum-distance order.
module mtwr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mtwr_pkg::win_rec_t rec,
    input  logic               rec_valid,
    output logic               pop,
    mtwr_out_if.source         results
);
    import mtwr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIST = 2'd1;
    localparam logic [1:0] ST_PICK = 2'd2;

    logic [1:0]                            state_reg;
    logic [WINDOW_MAX-1:0][DATA_WIDTH-1:0] words_reg;
    logic [WINDOW_MAX-1:0][POS_W-1:0]      pos_reg;
    logic [CNT_W-1:0]                      count_reg;
    logic [CNT_W-1:0]                      k_reg;
    logic [WINDOW_MAX-1:0]                 taken_reg;
    logic [WINDOW_MAX-1:0][DIST_W:0]       dist_reg;
    logic [WINDOW_MAX-1:0][DIST_W:0]       dist_next;
    logic [DATA_WIDTH-1:0]                 prev_reg;
    logic                                  out_valid_reg;
    logic [DATA_WIDTH-1:0]                 out_word_reg;
    logic [POS_W-1:0]                      out_pos_reg;
    logic                                  out_last_reg;
    logic [DIST_W:0]                       best_d;
    logic [POS_W-1:0]                      best;
    logic                                  slot_free;
    logic                                  pick_fire;
    logic                                  last;

    assign pop = (state_reg == ST_IDLE) && rec_valid;

    // Taken slots and slots past the window's end carry the top bit and never win.
    always_comb
    begin
        for (int j = 0; j < WINDOW_MAX; j++)
        begin
            if (taken_reg[j] || (j >= int'(count_reg)))
            begin
                dist_next[j] = {1'b1, {DIST_W{1'b0}}};
            end
            else
            begin
                dist_next[j] = {1'b0, bit_count(words_reg[j] ^ prev_reg)};
            end
        end
    end

    // Strictly smaller wins, so a tie keeps the lowest position.
    always_comb
    begin
        best_d = '1;
        best   = '0;
        for (int j = 0; j < WINDOW_MAX; j++)
        begin
            if (dist_reg[j] < best_d)
            begin
                best_d = dist_reg[j];
                best   = POS_W'(j);
            end
        end
    end

    assign slot_free = !out_valid_reg || results.ready;
    assign pick_fire = (state_reg == ST_PICK) && slot_free;
    assign last      = (CNT_W'(k_reg + 1'b1) == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            taken_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pick_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (rec_valid)
                    begin
                        count_reg <= rec.count;
                        k_reg     <= '0;
                        taken_reg <= '0;
                        state_reg <= ST_DIST;
                    end
                end
                ST_DIST:
                begin
                    state_reg <= ST_PICK;
                end
                ST_PICK:
                begin
                    if (slot_free)
                    begin
                        taken_reg[best] <= 1'b1;
                        prev_reg        <= words_reg[best];
                        k_reg           <= k_reg + 1'b1;
                        state_reg       <= last ? ST_IDLE : ST_DIST;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            words_reg <= rec.words;
            pos_reg   <= rec.pos;
        end
        if (state_reg == ST_DIST)
        begin
            dist_reg <= dist_next;
        end
        if (pick_fire)
        begin
            out_word_reg <= words_reg[best];
            out_pos_reg  <= pos_reg[best];
            out_last_reg <= last;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.out_word      = out_word_reg;
    assign results.orig_position = out_pos_reg;
    assign results.window_last   = out_last_reg;

endmodule

[rtl/core/min_transition_word_reorder_unit.sv]
// Top level of the minimum-transition word reorder unit.
//
//  channel   role    payload                                       request taken when
//  words     sink    data_word, end_of_stream                      valid && ready
//  results   source  out_word, orig_position, window_last          valid && ready
//  cfg       sink    window_size                                   valid && ready
//
// The front takes one word per cycle while the window queue (two windows) has room.
// Each result passes through the back's distance stage, then its pick stage, and each
// window is first loaded from the queue while the back is idle.
// A stalled results channel holds the back at its pick stage only.
// Reset is asynchronous, active low; window_size comes up as 4 and the previous word as 0.
module min_transition_word_reorder_unit (
    input  logic        clk,
    input  logic        rst_n,
    mtwr_in_if.sink     words,
    mtwr_cfg_if.sink    cfg,
    mtwr_out_if.source  results
);
    import mtwr_pkg::*;

    win_rec_t push_rec;
    win_rec_t pop_rec;
    logic     push;
    logic     full;
    logic     pop;
    logic     empty;

    mtwr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .words      (words),
        .cfg        (cfg),
        .queue_full (full),
        .queue_push (push),
        .queue_rec  (push_rec)
    );

    mtwr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (full),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .empty    (empty)
    );

    mtwr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (pop_rec),
        .rec_valid (!empty),
        .pop       (pop),
        .results   (results)
    );

endmodule

[rtl/core/mtwr_checker.sv]
// Port-level assertions for the reorder unit and the bind that attaches them.
module mtwr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            words_ready,
    input logic                            results_valid,
    input logic                            results_ready,
    input logic [mtwr_pkg::DATA_WIDTH-1:0] out_word,
    input logic [mtwr_pkg::POS_W-1:0]      orig_position,
    input logic                            window_last
);
    import mtwr_pkg::*;

    // A result that is not taken stays on the port unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=> results_valid && $stable(out_word)
            && $stable(orig_position) && $stable(window_last))
        else $error("result changed while stalled");

    // Out of reset no result is pending.
    a_reset_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !results_valid)
        else $error("result valid right after reset");

    // Out of reset the window queue is empty, so words are taken.
    a_reset_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> words_ready)
        else $error("words not ready right after reset");

endmodule

bind min_transition_word_reorder_unit mtwr_checker u_mtwr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .words_ready   (words.ready),
    .results_valid (results.valid),
    .results_ready (results.ready),
    .out_word      (results.out_word),
    .orig_position (results.orig_position),
    .window_last   (results.window_last)
);
